>>> rtl/counting_semaphore_waiter_queue_assert.svh
// assertion macros for the port-level checker
`ifndef COUNTING_SEMAPHORE_WAITER_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAITER_QUEUE_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define CSQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csq check failed");

// antecedent holds, consequent in the next cycle
`define CSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csq check failed");

`endif

>>> rtl/csq_pkg.sv
// types, codes and sizes of the semaphore waiter queue
package csq_pkg;

  localparam int unsigned MAX_WAITERS = 8;
  localparam int unsigned COUNT_MAX   = 32767;

  localparam int unsigned IDX_W   = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned TOTAL_W = $clog2(MAX_WAITERS + 1);
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned TID_W   = 32;
  localparam int unsigned IVAL_W  = 16;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned WAIT_W  = 4;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_TRYWAIT = 3'd1,
    OP_WAIT    = 3'd2,
    OP_POST    = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_DESTROY = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_LIST_FULL   = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_BUSY        = 3'd5,
    ST_INVALID     = 3'd6,
    ST_NOT_FOUND   = 3'd7
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // command broadcast to every queue cell
  typedef struct packed {
    logic             append;
    logic             del;
    logic [IDX_W-1:0] pos;
    logic [TID_W-1:0] tid;
  } cell_ctl_t;

endpackage

>>> rtl/counting_semaphore_waiter_queue.sv
// counting semaphore with a fifo queue of waiting thread ids
//
// usage:
//   input stream s_axis: one request per beat. tuser carries the operation
//   (init, trywait, wait, post, remove, destroy), tdata the thread id and
//   the init value. output stream m_axis: one result per request, carrying
//   status, count, queue length and a woken thread id (tuser = woken flag).
//
// timing:
//   a request is captured into the request register while idle and executed
//   in the execute state once the output register is free or being drained;
//   the result is then registered in the output register. the next request
//   is accepted only after the previous one has executed.
//   the waiter queue is a row of eight cells; every cell compares its id in
//   parallel and a delete shifts ids one cell forward at once.
//
// reset: rst (synchronous) zeroes the count and empties the queue; the
// stored ids are not cleared and are only read below the queue length.
// stall: a finished result waits in the output register; one more request
// is accepted and held until that register is taken.
module counting_semaphore_waiter_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // thread_id[31:0], init_value[47:32]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status[2:0], count_now[17:3],
                                      // waiters_now[21:18], woken_thread[53:22]
  output logic        m_axis_tuser    // woken_valid[0]
);

  localparam int unsigned NW = csq_pkg::MAX_WAITERS;

  // fsm and captured request
  csq_pkg::fsm_t                 state, state_next;
  logic [csq_pkg::OP_W-1:0]      req_op;
  logic [csq_pkg::TID_W-1:0]     req_tid;
  logic [csq_pkg::IVAL_W-1:0]    req_ival;

  // semaphore state
  logic [csq_pkg::COUNT_W-1:0]   count, count_next;
  logic [csq_pkg::TOTAL_W-1:0]   total, total_next;

  // output register
  logic                          out_valid;
  csq_pkg::status_t              out_status, status_next;
  logic [csq_pkg::COUNT_W-1:0]   out_count;
  logic [csq_pkg::TOTAL_W-1:0]   out_total;
  logic                          out_woken, woken_next;
  logic [csq_pkg::TID_W-1:0]     out_thread, thread_next;

  // cell row
  csq_pkg::cell_ctl_t            ctl;
  logic [csq_pkg::TID_W-1:0]     ids [NW];
  logic [NW-1:0]                 match;
  logic                          found;
  logic [csq_pkg::IDX_W-1:0]     found_pos;
  logic                          exec_fire;
  logic                          in_fire;

  // no request is taken while reset is held
  assign s_axis_tready = (state == csq_pkg::FSM_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // execute once the output register is free or being drained
  assign exec_fire     = (state == csq_pkg::FSM_EXEC) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csq_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      csq_pkg::FSM_IDLE: begin
        if (in_fire) state_next = csq_pkg::FSM_EXEC;
      end
      csq_pkg::FSM_EXEC: begin
        if (exec_fire) state_next = csq_pkg::FSM_IDLE;
      end
      default: state_next = csq_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op   <= s_axis_tuser;
      req_tid  <= s_axis_tdata[31:0];
      req_ival <= s_axis_tdata[47:32];
    end
  end

  // first occupied cell that holds the requested id
  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (match[i] && (csq_pkg::TOTAL_W'(i) < total)) begin
        found     = 1'b1;
        found_pos = csq_pkg::IDX_W'(i);
      end
    end
  end

  // operation decode
  always_comb begin
    count_next  = count;
    total_next  = total;
    status_next = csq_pkg::ST_OK;
    woken_next  = 1'b0;
    thread_next = '0;
    ctl.append  = 1'b0;
    ctl.del     = 1'b0;
    ctl.pos     = '0;
    ctl.tid     = req_tid;
    unique case (req_op)
      csq_pkg::OP_INIT: begin
        if (32'(req_ival) > csq_pkg::COUNT_MAX) begin
          status_next = csq_pkg::ST_INVALID;
        end else begin
          count_next = req_ival[csq_pkg::COUNT_W-1:0];
          total_next = '0;
        end
      end
      csq_pkg::OP_TRYWAIT: begin
        if (count != '0) begin
          count_next = count - csq_pkg::COUNT_W'(1);
        end else begin
          status_next = csq_pkg::ST_WOULD_BLOCK;
        end
      end
      csq_pkg::OP_WAIT: begin
        if (count != '0) begin
          count_next = count - csq_pkg::COUNT_W'(1);
        end else if (32'(total) >= NW) begin
          status_next = csq_pkg::ST_LIST_FULL;
        end else begin
          ctl.append  = exec_fire;
          ctl.pos     = total[csq_pkg::IDX_W-1:0];
          total_next  = total + csq_pkg::TOTAL_W'(1);
          status_next = csq_pkg::ST_QUEUED;
        end
      end
      csq_pkg::OP_POST: begin
        if (32'(count) >= csq_pkg::COUNT_MAX) begin
          status_next = csq_pkg::ST_OVERFLOW;
        end else begin
          count_next = count + csq_pkg::COUNT_W'(1);
          if (total != '0) begin
            woken_next  = 1'b1;
            thread_next = ids[0];
            ctl.del     = exec_fire;
            ctl.pos     = '0;
            total_next  = total - csq_pkg::TOTAL_W'(1);
          end
        end
      end
      csq_pkg::OP_REMOVE: begin
        if (found) begin
          ctl.del    = exec_fire;
          ctl.pos    = found_pos;
          total_next = total - csq_pkg::TOTAL_W'(1);
        end else begin
          status_next = csq_pkg::ST_NOT_FOUND;
        end
      end
      csq_pkg::OP_DESTROY: begin
        if (total != '0) begin
          status_next = csq_pkg::ST_BUSY;
        end else begin
          count_next = '0;
        end
      end
      default: status_next = csq_pkg::ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      count     <= count_next;
      total     <= total_next;
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status <= status_next;
      out_count  <= count_next;
      out_total  <= total_next;
      out_woken  <= woken_next;
      out_thread <= thread_next;
    end
  end

  // row of cells, each fed by the one behind it
  for (genvar g = 0; g < NW; g++) begin : g_cell
    logic [csq_pkg::TID_W-1:0] behind;
    if (g < NW - 1) begin : g_mid
      assign behind = ids[g+1];
    end else begin : g_last
      assign behind = ids[g];
    end
    csq_cell u_cell (
      .clk       (clk),
      .idx       (csq_pkg::IDX_W'(g)),
      .ctl       (ctl),
      .id_behind (behind),
      .id        (ids[g]),
      .match     (match[g])
    );
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_woken;
  assign m_axis_tdata  = {2'b00, out_thread,
                          csq_pkg::WAIT_W'(out_total), out_count, out_status};

endmodule

>>> rtl/csq_cell.sv
// one queue slot: holds an id, shifts from its neighbor on delete
module csq_cell (
  input  logic                       clk,
  input  logic [csq_pkg::IDX_W-1:0]  idx,
  input  csq_pkg::cell_ctl_t         ctl,
  input  logic [csq_pkg::TID_W-1:0]  id_behind,
  output logic [csq_pkg::TID_W-1:0]  id,
  output logic                       match
);

  always_ff @(posedge clk) begin
    if (ctl.append && (idx == ctl.pos)) begin
      id <= ctl.tid;
    end else if (ctl.del && (idx >= ctl.pos)) begin
      id <= id_behind;
    end
  end

  assign match = (id == ctl.tid);

endmodule

>>> rtl/csq_checker.sv
// port-level checks for the semaphore waiter queue, bound to the top level
`include "counting_semaphore_waiter_queue_assert.svh"

module csq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // queue length never exceeds its capacity
  `CSQ_ASSERT_SAME(a_waiters_cap, clk, rst, m_axis_tvalid, 32'(m_axis_tdata[21:18]) <= csq_pkg::MAX_WAITERS)
  // a wake notice only comes with an ok status
  `CSQ_ASSERT_SAME(a_woken_ok, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[2:0] == csq_pkg::ST_OK)
  // no woken id without the flag
  `CSQ_ASSERT_SAME(a_woken_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[53:22] == '0)
  // one request in flight: ready drops right after a request is taken
  `CSQ_ASSERT_NEXT(a_one_inflight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a stalled result holds
  `CSQ_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind counting_semaphore_waiter_queue csq_checker u_csq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> bench/tb_counting_semaphore_waiter_queue.sv
// testbench for the semaphore waiter queue: directed and random requests checked by a predictor
`timescale 1ns / 1ps

module tb_counting_semaphore_waiter_queue;
  import csq_pkg::*;

  // operation codes the block must reject as invalid
  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

  // watchdog limit, far above the length of the slowest correct run
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  // one expected result, fields as the output stream carries them
  typedef struct {
    status_t     status;
    logic [14:0] count;
    logic [3:0]  waiters;
    logic        woken;
    logic [31:0] woken_id;
  } sem_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // thread_id[31:0], init_value[47:32]
  logic [2:0]  s_axis_tuser = '0;   // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // status[2:0], count_now[17:3],
                                    // waiters_now[21:18], woken_thread[53:22]
  logic        m_axis_tuser;        // woken_valid[0]

  // predictor state: semaphore count and the fifo of waiting ids
  int unsigned sem_units;
  logic [31:0] sem_waiters[$];

  // results predicted but not yet seen on the output
  sem_result_t pending_results[$];

  // random idling on both sides, switched off for the last part of the run
  bit idle_on = 1'b0;

  int error_count;
  int sent_count;
  int checked_count;
  int wake_count;
  int cycle_count;
  int status_seen[8];

  counting_semaphore_waiter_queue u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // applies one request to the predictor state and returns its result
  function automatic sem_result_t semaphore_apply(input logic [2:0] op, input logic [31:0] tid,
                                                  input logic [15:0] ival);
    sem_result_t r;
    int hit;
    r.status   = ST_OK;
    r.woken    = 1'b0;
    r.woken_id = '0;
    case (op)
      OP_INIT: begin
        if (ival > COUNT_MAX) begin
          r.status = ST_INVALID;
        end else begin
          sem_units = ival;
          sem_waiters.delete();
        end
      end
      OP_TRYWAIT: begin
        if (sem_units > 0) sem_units--;
        else r.status = ST_WOULD_BLOCK;
      end
      OP_WAIT: begin
        if (sem_units > 0) begin
          sem_units--;
        end else if (sem_waiters.size() >= MAX_WAITERS) begin
          r.status = ST_LIST_FULL;
        end else begin
          sem_waiters.push_back(tid);
          r.status = ST_QUEUED;
        end
      end
      OP_POST: begin
        if (sem_units >= COUNT_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          sem_units++;
          if (sem_waiters.size() > 0) begin
            r.woken    = 1'b1;
            r.woken_id = sem_waiters.pop_front();
          end
        end
      end
      OP_REMOVE: begin
        // first match only, the rest of the queue closes up behind it
        hit = -1;
        foreach (sem_waiters[k]) if (hit < 0 && sem_waiters[k] == tid) hit = k;
        if (hit < 0) r.status = ST_NOT_FOUND;
        else sem_waiters.delete(hit);
      end
      OP_DESTROY: begin
        if (sem_waiters.size() > 0) r.status = ST_BUSY;
        else sem_units = 0;
      end
      default: r.status = ST_INVALID;
    endcase
    r.count   = sem_units[14:0];
    r.waiters = 4'(sem_waiters.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h, expected %h", checked_count, what, got, want);
    error_count++;
  endtask

  // drives one request and waits for its handshake; an idle burst may come first
  task automatic issue_request(input logic [2:0] op, input logic [31:0] tid,
                               input logic [15:0] ival);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ival, tid};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(semaphore_apply(op, tid, ival));
    sent_count++;
  endtask

  // compares one accepted result with the oldest prediction
  task automatic check_result();
    sem_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", m_axis_tdata[31:0], '0);
      return;
    end
    want = pending_results.pop_front();
    if (m_axis_tdata[2:0] !== want.status)
      report_mismatch("status", m_axis_tdata[2:0], want.status);
    if (m_axis_tdata[17:3] !== want.count)
      report_mismatch("count_now", m_axis_tdata[17:3], want.count);
    if (m_axis_tdata[21:18] !== want.waiters)
      report_mismatch("waiters_now", m_axis_tdata[21:18], want.waiters);
    if (m_axis_tuser !== want.woken)
      report_mismatch("woken_valid", m_axis_tuser, want.woken);
    if (m_axis_tdata[53:22] !== want.woken_id)
      report_mismatch("woken_thread", m_axis_tdata[53:22], want.woken_id);
    checked_count++;
    status_seen[want.status]++;
    if (want.woken) wake_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
  end

  // result side: random stall bursts while idling is on, otherwise always ready
  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // out of reset: count zero, queue empty
  task automatic test_reset_state();
    issue_request(OP_DESTROY, 32'h0, 16'h0);   // destroy with no waiters
    issue_request(OP_TRYWAIT, 32'h0, 16'h0);   // would block at zero
    issue_request(OP_POST, 32'h0, 16'h0);      // post with nobody to wake
  endtask

  // queueing, busy destroy, removal and wake order
  task automatic test_wait_queue();
    issue_request(OP_TRYWAIT, 32'h0, 16'h0);
    issue_request(OP_WAIT, 32'hFFFF_FFFF, 16'hFFFF);
    issue_request(OP_WAIT, 32'h0, 16'h0);
    issue_request(OP_DESTROY, 32'h0, 16'h0);          // busy while waiters exist
    issue_request(OP_REMOVE, 32'h1234_5678, 16'h0);   // id not queued
    issue_request(OP_REMOVE, 32'h0, 16'h0);           // removes the tail entry
    issue_request(OP_POST, 32'h0, 16'h0);             // wakes the all-ones id
  endtask

  // init range check, overflow at the maximum, unused operation codes
  task automatic test_count_limits();
    issue_request(OP_INIT, 32'h0, 16'hFFFF);
    issue_request(OP_INIT, 32'h0, 16'(COUNT_MAX + 1));
    issue_request(OP_INIT, 32'h0, 16'(COUNT_MAX));
    issue_request(OP_POST, 32'h0, 16'h0);
    issue_request(OP_RESERVED_LO, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // fill the queue, one wait past full, first-match removal, init clears
  task automatic test_full_queue();
    logic [31:0] tid;
    issue_request(OP_INIT, 32'h0, 16'h0);
    for (int k = 0; k < MAX_WAITERS; k++) begin
      tid = (k == 5) ? 32'hA500_0002 : (32'hA500_0000 | k);   // one duplicate id
      issue_request(OP_WAIT, tid, 16'h0);
    end
    issue_request(OP_WAIT, 32'hDEAD_BEEF, 16'h0);
    issue_request(OP_REMOVE, 32'hA500_0002, 16'h0);
    issue_request(OP_INIT, 32'h0, 16'h5);
  endtask

  // weighted mix: mostly wait/post traffic so the queue fills and drains
  task automatic test_random_traffic(input int n);
    logic [31:0] id_pool[4];
    logic [2:0]  op;
    logic [31:0] tid;
    logic [15:0] ival;
    int          w;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = $urandom;
    id_pool[3] = $urandom;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 30) op = OP_WAIT;
      else if (w < 55) op = OP_POST;
      else if (w < 68) op = OP_REMOVE;
      else if (w < 78) op = OP_TRYWAIT;
      else if (w < 87) op = OP_INIT;
      else if (w < 95) op = OP_DESTROY;
      else op = ($urandom_range(0, 1) != 0) ? OP_RESERVED_HI : OP_RESERVED_LO;

      // removes usually hit a queued id; a small pool makes duplicates common
      w = $urandom_range(0, 99);
      if (op == OP_REMOVE && sem_waiters.size() > 0 && w < 70)
        tid = sem_waiters[$urandom_range(0, sem_waiters.size() - 1)];
      else if (w < 50)
        tid = id_pool[$urandom_range(0, 3)];
      else
        tid = $urandom;

      // init mostly small counts, sometimes near or above the maximum
      w = $urandom_range(0, 99);
      if (op != OP_INIT) ival = 16'($urandom_range(0, 65535));
      else if (w < 60) ival = 16'($urandom_range(0, 4));
      else if (w < 75) ival = 16'($urandom_range(COUNT_MAX - 7, COUNT_MAX));
      else if (w < 85) ival = 16'($urandom_range(COUNT_MAX + 1, 65535));
      else ival = 16'($urandom_range(0, 65535));

      issue_request(op, tid, ival);
    end
  endtask

  initial begin
    sem_units = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    test_reset_state();
    test_wait_queue();
    test_count_limits();
    test_full_queue();
    test_random_traffic(1350);

    // back-to-back traffic with the result side always ready
    idle_on = 1'b0;
    test_random_traffic(300);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d wakeups, %0d queued waits",
             sent_count, checked_count, wake_count, status_seen[ST_QUEUED]);
    $display("summary: %0d list full, %0d overflow, %0d busy, %0d invalid, %0d not found",
             status_seen[ST_LIST_FULL], status_seen[ST_OVERFLOW], status_seen[ST_BUSY],
             status_seen[ST_INVALID], status_seen[ST_NOT_FOUND]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
